// File: design/height_map_to_normal_map_assert.svh
// assertion macros shared by the height map to normal map block
`ifndef HEIGHT_MAP_TO_NORMAL_MAP_ASSERT_SVH
`define HEIGHT_MAP_TO_NORMAL_MAP_ASSERT_SVH

// property checked on every clock edge outside reset
`define HNM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must hold in the cycle after a trigger
`define HNM_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

// File: design/hnm_pkg.sv
// types and constants of the height map to normal map block
package hnm_pkg;

  localparam int MaxSideDef     = 1024;
  localparam int NormalFracBits = 14;

  localparam int HeightW  = 8;
  localparam int SideW    = 11;
  localparam int ScaleW   = 16;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;
  localparam int CoordW   = 10;
  localparam int NrmW     = 16;
  localparam int NrmZW    = 15;
  localparam int DiffW    = HeightW + 1;
  localparam int GradMagW = 24;

  localparam logic [SideW-1:0]  SideRst  = 11'd1024;
  localparam logic [ScaleW-1:0] ScaleRst = 16'd4096;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_IMAGE_SIDE   = 2'd0,
    CFG_CENTER_SCALE = 2'd1,
    CFG_EDGE_SCALE   = 2'd2
  } cfg_idx_e;

  // one gradient job handed from the sequencer to the normal unit
  typedef struct packed {
    logic signed [DiffW-1:0] dx;
    logic                    edge_x;
    logic signed [DiffW-1:0] dy;
    logic                    edge_y;
    logic [CoordW-1:0]       row;
    logic [CoordW-1:0]       col;
    logic                    last;
  } nrm_job_t;

  typedef enum logic [2:0] {
    CT_IDLE,
    CT_RD1,
    CT_RD2,
    CT_JOB1,
    CT_JOB2,
    CT_JOB3,
    CT_UPD
  } ctl_state_e;

  typedef enum logic [2:0] {
    NU_IDLE,
    NU_MUL,
    NU_SQ,
    NU_SUM,
    NU_ROOT,
    NU_DINIT,
    NU_DIV,
    NU_OUT
  } nrm_state_e;

endpackage

// File: design/hnm_ram.sv
// generic single write port ram with registered read
module hnm_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                     wdata_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                     rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// File: design/hnm_ctrl.sv
// pixel sequencer: line buffer read-modify-write, window and gradient jobs
module hnm_ctrl #(
  parameter int MaxSide = hnm_pkg::MaxSideDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [hnm_pkg::HeightW-1:0]   height_i,
  input  logic [hnm_pkg::SideW-1:0]     image_side_i,
  input  logic                          side_wr_i,
  output logic                          job_valid_o,
  input  logic                          job_ready_i,
  output hnm_pkg::nrm_job_t             job_o
);
  import hnm_pkg::*;

  localparam int CW = (MaxSide > 1) ? $clog2(MaxSide) : 1;
  localparam int NW = $clog2(MaxSide + 1);
  localparam int PW = NW + 1;

  ctl_state_e state_q, state_d;

  logic [CW-1:0]      row_q, col_q;
  logic [HeightW-1:0] win0_q, win1_q, win2_q;
  logic [HeightW-1:0] h_q, cen_q, up_q, right_q;

  logic [NW-1:0] n;
  logic          pos_ok;
  logic [CW-1:0] r, c;
  logic          c_first, c_last, c1_first, r1_first, r_last;
  logic          need1, need2, need3;
  logic [CW-1:0] c_inc, r_inc;

  logic [CW-1:0]      rd_addr_recent;
  logic [HeightW-1:0] recent_rd, older_rd;
  logic               mem_we;

  nrm_job_t job1, job2, job3;

  // difference for one axis, one-sided at the borders
  function automatic logic signed [DiffW-1:0] diff3(
    input logic first, input logic lst,
    input logic [HeightW-1:0] b, input logic [HeightW-1:0] m,
    input logic [HeightW-1:0] a);
    logic signed [DiffW-1:0] sb, sm, sa, res;
    sb = $signed({1'b0, b});
    sm = $signed({1'b0, m});
    sa = $signed({1'b0, a});
    if (first) begin
      res = sa - sm;
    end else if (lst) begin
      res = sm - sb;
    end else begin
      res = sa - sb;
    end
    return res;
  endfunction

  // effective side and position of the pending pixel
  always_comb begin
    if (image_side_i < SideW'(2)) begin
      n = NW'(2);
    end else if (int'(image_side_i) > MaxSide) begin
      n = NW'(MaxSide);
    end else begin
      n = NW'(image_side_i);
    end
    pos_ok   = (PW'(row_q) < PW'(n)) && (PW'(col_q) < PW'(n));
    r        = pos_ok ? row_q : '0;
    c        = pos_ok ? col_q : '0;
    c_first  = (c == '0);
    c_last   = (PW'(c) + PW'(1) == PW'(n));
    c1_first = (c == CW'(1));
    r1_first = (r == CW'(1));
    r_last   = (PW'(r) + PW'(1) == PW'(n));
    need1    = (r != '0);
    need2    = r_last && !c_first;
    need3    = r_last && c_last;
    c_inc    = c + CW'(1);
    r_inc    = r + CW'(1);
  end

  // gradient jobs of the three possible normals
  always_comb begin
    job1.dx     = diff3(c_first, c_last, win0_q, cen_q, right_q);
    job1.edge_x = c_first | c_last;
    job1.dy     = diff3(r1_first, 1'b0, up_q, cen_q, h_q);
    job1.edge_y = r1_first;
    job1.row    = CoordW'(r - CW'(1));
    job1.col    = CoordW'(c);
    job1.last   = 1'b0;

    job2.dx     = diff3(c1_first, 1'b0, win2_q, win1_q, h_q);
    job2.edge_x = c1_first;
    job2.dy     = diff3(1'b0, 1'b1, win0_q, win1_q, '0);
    job2.edge_y = 1'b1;
    job2.row    = CoordW'(r);
    job2.col    = CoordW'(c - CW'(1));
    job2.last   = 1'b0;

    job3.dx     = diff3(1'b0, 1'b1, win1_q, h_q, '0);
    job3.edge_x = 1'b1;
    job3.dy     = diff3(1'b0, 1'b1, cen_q, h_q, '0);
    job3.edge_y = 1'b1;
    job3.row    = CoordW'(r);
    job3.col    = CoordW'(c);
    job3.last   = 1'b1;
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CT_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state, handshake and memory control
  always_comb begin
    state_d        = state_q;
    in_ready_o     = 1'b0;
    job_valid_o    = 1'b0;
    job_o          = job1;
    rd_addr_recent = c;
    mem_we         = 1'b0;
    case (state_q)
      CT_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = CT_RD1;
        end
      end
      CT_RD1: begin
        rd_addr_recent = c_inc;
        mem_we         = 1'b1;
        state_d        = CT_RD2;
      end
      CT_RD2: begin
        state_d = CT_JOB1;
      end
      CT_JOB1: begin
        job_valid_o = need1;
        job_o       = job1;
        if (!need1 || job_ready_i) begin
          state_d = CT_JOB2;
        end
      end
      CT_JOB2: begin
        job_valid_o = need2;
        job_o       = job2;
        if (!need2 || job_ready_i) begin
          state_d = CT_JOB3;
        end
      end
      CT_JOB3: begin
        job_valid_o = need3;
        job_o       = job3;
        if (!need3 || job_ready_i) begin
          state_d = CT_UPD;
        end
      end
      CT_UPD: begin
        state_d = CT_IDLE;
      end
      default: begin
        state_d = CT_IDLE;
      end
    endcase
  end

  // line buffers
  hnm_ram #(.Width(HeightW), .Depth(MaxSide)) u_recent (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (c),
    .wdata_i (h_q),
    .raddr_i (rd_addr_recent),
    .rdata_o (recent_rd)
  );

  hnm_ram #(.Width(HeightW), .Depth(MaxSide)) u_older (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (c),
    .wdata_i (recent_rd),
    .raddr_i (c),
    .rdata_o (older_rd)
  );

  // counters and window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      win0_q <= '0;
      win1_q <= '0;
      win2_q <= '0;
    end else begin
      if (state_q == CT_UPD) begin
        win2_q <= win1_q;
        win1_q <= h_q;
        win0_q <= cen_q;
      end
      if (side_wr_i) begin
        row_q <= '0;
        col_q <= '0;
      end else if (state_q == CT_UPD) begin
        if (c_last) begin
          col_q <= '0;
          row_q <= r_last ? '0 : r_inc;
        end else begin
          col_q <= c_inc;
        end
      end
    end
  end

  // captured samples of the current transaction
  always_ff @(posedge clk_i) begin
    if (state_q == CT_IDLE && in_valid_i) begin
      h_q <= height_i;
    end
    if (state_q == CT_RD1) begin
      cen_q <= recent_rd;
      up_q  <= older_rd;
    end
    if (state_q == CT_RD2) begin
      right_q <= c_last ? '0 : recent_rd;
    end
  end
endmodule

// File: design/hnm_norm.sv
// normal unit: scaled gradients, iterative square root and three divide lanes
module hnm_norm (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             job_valid_i,
  output logic                             job_ready_o,
  input  hnm_pkg::nrm_job_t                job_i,
  input  logic [hnm_pkg::ScaleW-1:0]       center_scale_i,
  input  logic [hnm_pkg::ScaleW-1:0]       edge_scale_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [hnm_pkg::NrmW-1:0]  normal_x_o,
  output logic signed [hnm_pkg::NrmW-1:0]  normal_y_o,
  output logic [hnm_pkg::NrmZW-1:0]        normal_z_o,
  output logic [hnm_pkg::CoordW-1:0]       pixel_row_o,
  output logic [hnm_pkg::CoordW-1:0]       pixel_col_o,
  output logic                             last_of_image_o
);
  import hnm_pkg::*;

  localparam int ProdW  = DiffW + ScaleW + 1;
  localparam int SqW    = 2 * GradMagW;
  localparam int VW     = 2 * GradMagW + 9;
  localparam int TopBit = ((VW - 1) / 2) * 2;
  localparam int RW     = (VW + 1) / 2;
  localparam int DW     = RW + 1;
  localparam int ShiftN = NormalFracBits + 5;
  localparam int NumW   = GradMagW + ShiftN + 1;
  localparam int QW     = NormalFracBits + 1;
  localparam int CntW   = $clog2(QW);
  localparam logic [GradMagW-1:0] OneMag = GradMagW'(4096);

  nrm_state_e state_q, state_d;
  nrm_job_t   job_q;

  logic signed [ProdW-1:0] gx_q, gy_q;
  logic [ProdW-1:0]        ax, ay;
  logic [GradMagW-1:0]     mx_q, my_q;
  logic                    negx_q, negy_q;
  logic [SqW-1:0]          sqx_q, sqy_q;
  logic [VW-1:0]           rem_q, res_q, bit_q, trial;
  logic [DW-1:0]           dvs_q;
  logic [DW-1:0]           drem_q [3];
  logic [QW-1:0]           dnum_q [3];
  logic [QW-1:0]           quo_q  [3];
  logic [GradMagW-1:0]     lane_mag [3];
  logic [CntW-1:0]         dcnt_q;

  assign ax          = gx_q[ProdW-1] ? -gx_q : gx_q;
  assign ay          = gy_q[ProdW-1] ? -gy_q : gy_q;
  assign trial       = res_q + bit_q;
  assign lane_mag[0] = mx_q;
  assign lane_mag[1] = my_q;
  assign lane_mag[2] = OneMag;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= NU_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and handshakes
  always_comb begin
    state_d     = state_q;
    job_ready_o = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      NU_IDLE: begin
        job_ready_o = 1'b1;
        if (job_valid_i) begin
          state_d = NU_MUL;
        end
      end
      NU_MUL:   state_d = NU_SQ;
      NU_SQ:    state_d = NU_SUM;
      NU_SUM:   state_d = NU_ROOT;
      NU_ROOT: begin
        if (bit_q[0]) begin
          state_d = NU_DINIT;
        end
      end
      NU_DINIT: state_d = NU_DIV;
      NU_DIV: begin
        if (dcnt_q == '0) begin
          state_d = NU_OUT;
        end
      end
      NU_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = NU_IDLE;
        end
      end
      default: state_d = NU_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      NU_IDLE: begin
        if (job_valid_i) begin
          job_q <= job_i;
        end
      end
      // scaled gradients
      NU_MUL: begin
        gx_q <= job_q.dx *
                $signed({1'b0, job_q.edge_x ? edge_scale_i : center_scale_i});
        gy_q <= job_q.dy *
                $signed({1'b0, job_q.edge_y ? edge_scale_i : center_scale_i});
      end
      // magnitudes and squares
      NU_SQ: begin
        mx_q   <= ax[GradMagW-1:0];
        my_q   <= ay[GradMagW-1:0];
        negx_q <= gx_q[ProdW-1];
        negy_q <= gy_q[ProdW-1];
        sqx_q  <= ax[GradMagW-1:0] * ax[GradMagW-1:0];
        sqy_q  <= ay[GradMagW-1:0] * ay[GradMagW-1:0];
      end
      // squared length plus one, scaled for the root
      NU_SUM: begin
        rem_q <= (VW'(sqx_q) + VW'(sqy_q) + (VW'(1) << 24)) << 8;
        res_q <= '0;
        bit_q <= VW'(1) << TopBit;
      end
      // one result bit per step of the integer square root
      NU_ROOT: begin
        if (rem_q >= trial) begin
          rem_q <= rem_q - trial;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      // rounded quotients: (mag * 2^(f+5) + r) / 2r
      NU_DINIT: begin
        dvs_q  <= {res_q[RW-1:0], 1'b0};
        dcnt_q <= CntW'(QW - 1);
        for (int i = 0; i < 3; i++) begin
          drem_q[i] <= DW'(((NumW'(lane_mag[i]) << ShiftN) + NumW'(res_q[RW-1:0])) >> QW);
          dnum_q[i] <= QW'((NumW'(lane_mag[i]) << ShiftN) + NumW'(res_q[RW-1:0]));
        end
      end
      // restoring division, one quotient bit per lane per cycle
      NU_DIV: begin
        dcnt_q <= dcnt_q - CntW'(1);
        for (int i = 0; i < 3; i++) begin
          if ({drem_q[i], dnum_q[i][QW-1]} >= {1'b0, dvs_q}) begin
            drem_q[i] <= DW'({drem_q[i], dnum_q[i][QW-1]} - {1'b0, dvs_q});
            quo_q[i]  <= {quo_q[i][QW-2:0], 1'b1};
          end else begin
            drem_q[i] <= {drem_q[i][DW-2:0], dnum_q[i][QW-1]};
            quo_q[i]  <= {quo_q[i][QW-2:0], 1'b0};
          end
          dnum_q[i] <= dnum_q[i] << 1;
        end
      end
      default: begin
      end
    endcase
  end

  // result register contents with signs restored
  assign normal_x_o      = negx_q ? -$signed(NrmW'(quo_q[0])) : $signed(NrmW'(quo_q[0]));
  assign normal_y_o      = negy_q ? -$signed(NrmW'(quo_q[1])) : $signed(NrmW'(quo_q[1]));
  assign normal_z_o      = NrmZW'(quo_q[2]);
  assign pixel_row_o     = job_q.row;
  assign pixel_col_o     = job_q.col;
  assign last_of_image_o = job_q.last;
endmodule

// File: design/height_map_to_normal_map.sv
// Height map to normal map. Takes 8-bit height samples of a square image in
// raster order and returns one Q1.14 unit normal per pixel, tagged with its
// row and column, as soon as the pixel's neighbours have arrived; the final
// sample of the image flushes the bottom row. Two line buffer RAMs hold the
// previous two rows. Each input transaction passes through the sequencer and
// waits for the normal unit once per normal that it releases (0 to 3). The
// normal unit computes a normal by the scaling multiplies, an iterative
// square root and a division, then hands it off. The result register lets
// the next transaction start while a normal waits to be taken. Writing
// image_side restarts the image at row 0, column 0.
`include "height_map_to_normal_map_assert.svh"

module height_map_to_normal_map #(
  parameter int MaxSide = hnm_pkg::MaxSideDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [hnm_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [hnm_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [hnm_pkg::HeightW-1:0]      height_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [hnm_pkg::NrmW-1:0]  normal_x_o,
  output logic signed [hnm_pkg::NrmW-1:0]  normal_y_o,
  output logic [hnm_pkg::NrmZW-1:0]        normal_z_o,
  output logic [hnm_pkg::CoordW-1:0]       pixel_row_o,
  output logic [hnm_pkg::CoordW-1:0]       pixel_col_o,
  output logic                             last_of_image_o
);
  import hnm_pkg::*;

  logic [SideW-1:0]  image_side_q;
  logic [ScaleW-1:0] center_scale_q, edge_scale_q;
  logic              side_wr;
  logic              job_valid, job_ready;
  nrm_job_t          job;

  assign cfg_ready_o = 1'b1;
  assign side_wr     = cfg_valid_i && (cfg_idx_e'(cfg_index_i) == CFG_IMAGE_SIDE);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_side_q   <= SideRst;
      center_scale_q <= ScaleRst;
      edge_scale_q   <= ScaleRst;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_IMAGE_SIDE:   image_side_q   <= cfg_data_i[SideW-1:0];
        CFG_CENTER_SCALE: center_scale_q <= cfg_data_i[ScaleW-1:0];
        CFG_EDGE_SCALE:   edge_scale_q   <= cfg_data_i[ScaleW-1:0];
        default: begin
        end
      endcase
    end
  end

  // pixel sequencer with line buffers
  hnm_ctrl #(.MaxSide(MaxSide)) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .height_i     (height_i),
    .image_side_i (image_side_q),
    .side_wr_i    (side_wr),
    .job_valid_o  (job_valid),
    .job_ready_i  (job_ready),
    .job_o        (job)
  );

  // normal unit with result register
  hnm_norm u_norm (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_valid_i     (job_valid),
    .job_ready_o     (job_ready),
    .job_i           (job),
    .center_scale_i  (center_scale_q),
    .edge_scale_i    (edge_scale_q),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .normal_x_o      (normal_x_o),
    .normal_y_o      (normal_y_o),
    .normal_z_o      (normal_z_o),
    .pixel_row_o     (pixel_row_o),
    .pixel_col_o     (pixel_col_o),
    .last_of_image_o (last_of_image_o)
  );

  // checks
  `HNM_ASSERT_NEXT(a_one_item, in_valid_i && in_ready_o, !in_ready_o, "second item taken early")
  `HNM_ASSERT(a_last_diag, (out_valid_o && last_of_image_o) |-> (pixel_row_o == pixel_col_o), "last not on corner")
  `HNM_ASSERT(a_z_pos, out_valid_o |-> (normal_z_o != '0), "zero z component")
endmodule

// File: sim/testbench.sv
// testbench for the height map to normal map block: directed and random images
module testbench;
  import hnm_pkg::*;

  localparam int ClockLimit = 3000000;
  localparam int MaxSide    = 1024;

  typedef struct packed {
    logic [NrmW-1:0]   nx;
    logic [NrmW-1:0]   ny;
    logic [NrmZW-1:0]  nz;
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] col;
    logic              last;
  } normal_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [HeightW-1:0] height_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [NrmW-1:0] normal_x_o;
  logic signed [NrmW-1:0] normal_y_o;
  logic [NrmZW-1:0] normal_z_o;
  logic [CoordW-1:0] pixel_row_o;
  logic [CoordW-1:0] pixel_col_o;
  logic last_of_image_o;

  height_map_to_normal_map u_top (.*);

  // expected normals, oldest first
  normal_t pending_normals[$];
  int unsigned errors = 0;
  int unsigned normals_checked = 0;
  int unsigned heights_sent = 0;
  int unsigned cfg_writes = 0;
  int unsigned cycles = 0;
  int unsigned hold_cycles = 0;
  bit sender_quiet = 0;
  bit receiver_quiet = 0;

  // shadow of the block state
  logic [7:0] older_row[MaxSide];
  logic [7:0] recent_row[MaxSide];
  logic [7:0] win_up_left, win_prev, win_prev2;
  int unsigned cur_row, cur_col;
  int unsigned side_reg, center_scale, edge_scale;

  // clock and cycle limit
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > ClockLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("testbench: done, errors");
      $finish;
    end
  end

  function automatic int unsigned active_side();
    if (side_reg < 2) return 2;
    if (side_reg > MaxSide) return MaxSide;
    return side_reg;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint slope(int unsigned pos, int unsigned n, int bef, int mid,
                                   int aft);
    if (pos == 0) return longint'(aft - mid) * longint'(edge_scale);
    if (pos == n - 1) return longint'(mid - bef) * longint'(edge_scale);
    return longint'(aft - bef) * longint'(center_scale);
  endfunction

  function automatic longint unsigned unit_part(longint g, longint unsigned r);
    longint unsigned mag, q;
    mag = (g < 0) ? longint'(-g) : longint'(g);
    q = ((mag << (NormalFracBits + 5)) + r) / (2 * r);
    if (g < 0) q = 64'd0 - q;
    return q;
  endfunction

  // queue the normal of one pixel from its four neighbours
  function automatic void push_normal(int unsigned row, int unsigned col, int unsigned n,
                                      int left, int center, int right, int up, int down,
                                      bit last);
    longint gx, gy;
    longint unsigned s, r;
    normal_t e;
    gx = slope(col, n, left, center, right);
    gy = slope(row, n, up, center, down);
    s = longint'(gx * gx) + longint'(gy * gy) + 64'd4096 * 64'd4096;
    r = int_sqrt(s << 8);
    e.nx = NrmW'(unit_part(gx, r));
    e.ny = NrmW'(unit_part(gy, r));
    e.nz = NrmZW'(unit_part(4096, r));
    e.row = CoordW'(row);
    e.col = CoordW'(col);
    e.last = last;
    pending_normals.push_back(e);
  endfunction

  // advance the shadow state by one accepted sample
  function automatic void predict_height(logic [7:0] h);
    int unsigned n, r, c;
    int right;
    n = active_side();
    r = cur_row;
    c = cur_col;
    if (r >= n || c >= n) begin
      r = 0;
      c = 0;
    end
    if (r >= 1) begin
      right = (c + 1 < n) ? recent_row[c+1] : 0;
      push_normal(r - 1, c, n, win_up_left, recent_row[c], right, older_row[c], h, 0);
    end
    if (r == n - 1 && c >= 1)
      push_normal(r, c - 1, n, win_prev2, win_prev, h, win_up_left, 0, 0);
    if (r == n - 1 && c == n - 1)
      push_normal(r, c, n, win_prev, h, 0, recent_row[c], 0, 1);
    win_prev2 = win_prev;
    win_prev = h;
    win_up_left = recent_row[c];
    older_row[c] = recent_row[c];
    recent_row[c] = h;
    c++;
    if (c >= n) begin
      c = 0;
      r++;
      if (r >= n) r = 0;
    end
    cur_row = r;
    cur_col = c;
  endfunction

  // one height transaction; valid stays up until the next call or stop_heights
  task automatic send_height(logic [7:0] h);
    int unsigned gap;
    gap = sender_quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    height_i <= h;
    do @(posedge clk_i); while (!in_ready_o);
    predict_height(h);
    heights_sent++;
  endtask

  task automatic stop_heights();
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_normals.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  // register write while the block is idle
  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] data);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_IMAGE_SIDE: begin
        side_reg = data & 16'h07FF;
        cur_row = 0;
        cur_col = 0;
      end
      CFG_CENTER_SCALE: center_scale = data;
      CFG_EDGE_SCALE: edge_scale = data;
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic set_config(logic [CfgDataW-1:0] side, logic [CfgDataW-1:0] cs,
                            logic [CfgDataW-1:0] es);
    write_reg(CFG_CENTER_SCALE, cs);
    write_reg(CFG_EDGE_SCALE, es);
    write_reg(CFG_IMAGE_SIDE, side);
  endtask

  task automatic send_random(int unsigned count);
    repeat (count) send_height($urandom_range(0, 255));
    stop_heights();
  endtask

  // receiver: random stalls, optional long hold, check each normal
  initial begin
    normal_t got, want;
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      if (hold_cycles > 0) begin
        out_ready_i <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end else begin
        stall = receiver_quiet ? 0 : $urandom_range(0, 14);
        if (stall > 0) begin
          out_ready_i <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      got = '{normal_x_o, normal_y_o, normal_z_o, pixel_row_o, pixel_col_o,
              last_of_image_o};
      if (pending_normals.size() == 0) begin
        $display("%0t: unexpected normal %h", $time, got);
        errors++;
      end else begin
        want = pending_normals.pop_front();
        normals_checked++;
        if (got.nx !== want.nx) begin
          $display("%0t: normal_x exp %h got %h", $time, want.nx, got.nx); errors++;
        end
        if (got.ny !== want.ny) begin
          $display("%0t: normal_y exp %h got %h", $time, want.ny, got.ny); errors++;
        end
        if (got.nz !== want.nz) begin
          $display("%0t: normal_z exp %h got %h", $time, want.nz, got.nz); errors++;
        end
        if (got.row !== want.row) begin
          $display("%0t: pixel_row exp %0d got %0d", $time, want.row, got.row); errors++;
        end
        if (got.col !== want.col) begin
          $display("%0t: pixel_col exp %0d got %0d", $time, want.col, got.col); errors++;
        end
        if (got.last !== want.last) begin
          $display("%0t: last exp %0d got %0d", $time, want.last, got.last); errors++;
        end
      end
    end
  end

  // reset side: start of the top row of a 1024 wide image, no normal released yet
  task automatic test_reset_side();
    send_random(150);
  endtask

  // side written out of range: below 2, above the maximum, upper bits ignored
  task automatic test_side_clamp();
    set_config(16'd1, 16'd4096, 16'd4096);
    send_random(8);
    set_config(16'd0, 16'hFFFF, 16'd0);
    send_random(4);
    set_config(16'hF802, 16'd0, 16'hFFFF);
    send_random(4);
    set_config(16'h07FF, 16'd4096, 16'd4096);
    send_random(5);
  endtask

  // steepest slopes, flat images and extreme heights
  task automatic test_extremes();
    set_config(16'd3, 16'hFFFF, 16'hFFFF);
    for (int i = 0; i < 9; i++) send_height((i % 2) ? 8'hFF : 8'h00);
    stop_heights();
    set_config(16'd3, 16'd0, 16'd0);
    for (int i = 0; i < 9; i++) send_height(8'hFF);
    stop_heights();
    set_config(16'd4, 16'd4096, 16'd2048);
    for (int i = 0; i < 16; i++) send_height(8'(i * 17));
    stop_heights();
  endtask

  // long receiver hold while the sender keeps offering samples
  task automatic test_backpressure();
    set_config(16'd4, 16'd12345, 16'd777);
    sender_quiet = 1;
    hold_cycles = 3000;
    send_random(32);
    sender_quiet = 0;
  endtask

  // random images, mostly small and complete, some cut short
  task automatic test_random();
    int unsigned side, imgs;
    logic [15:0] cs, es;
    while (heights_sent < 450) begin
      case ($urandom_range(0, 9))
        0: side = $urandom_range(7, 10);
        1: side = $urandom_range(0, 1);
        default: side = $urandom_range(2, 6);
      endcase
      cs = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
      es = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
      sender_quiet = ($urandom_range(0, 3) == 0);
      receiver_quiet = ($urandom_range(0, 3) == 0);
      set_config(16'(side) | (16'($urandom_range(0, 31)) << 11), cs, es);
      if (side < 2) side = 2;
      imgs = (side > 6) ? 1 : $urandom_range(1, 3);
      if ($urandom_range(0, 4) == 0)
        send_random($urandom_range(1, side * side - 1));
      else
        send_random(imgs * side * side);
    end
    sender_quiet = 0;
    receiver_quiet = 0;
  endtask

  initial begin
    for (int i = 0; i < MaxSide; i++) begin
      older_row[i] = 8'd0;
      recent_row[i] = 8'd0;
    end
    win_up_left = 0;
    win_prev = 0;
    win_prev2 = 0;
    cur_row = 0;
    cur_col = 0;
    side_reg = 1024;
    center_scale = 4096;
    edge_scale = 4096;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_side();
    test_side_clamp();
    test_extremes();
    test_backpressure();
    test_random();

    while (pending_normals.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    $display("covered %0d height samples and %0d normals over %0d register writes",
             heights_sent, normals_checked, cfg_writes);
    $display("sides from clamped 2 up to 1024, scales at zero, unity and full range");
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
